[sv/shs_pkg.sv]
// Shared types and constants for the stage homing sequencer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package shs_pkg;

  localparam int unsigned ARG_W   = 32;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned POLL_W  = 24;
  localparam int unsigned JOG_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Truncating divide by ten of a 24-bit speed: multiply by ceil(2^27 / 10)
  // and keep the bits above 27. Exact for every value below 2^26.
  localparam logic [SPEED_W-1:0] SPEED_DIV_MULT  = 24'hCCCCCD;
  localparam int unsigned        SPEED_DIV_SHIFT = 27;

  localparam logic [SPEED_W-1:0] RUN_SPEED_RST  = 24'd1000;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RST = 24'd100;
  localparam logic [POLL_W-1:0]  POLL_LIMIT_RST = 24'd1000000;
  localparam logic [JOG_W-1:0]   JOG_LIMIT_RST  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_SPEED     = 3'd0,
    REG_APPROACH_DIST = 3'd1,
    REG_JOG_DIST      = 3'd2,
    REG_SLOW_DIST     = 3'd3,
    REG_HOME_OFFSET   = 3'd4,
    REG_POLL_LIMIT    = 3'd5,
    REG_JOG_LIMIT     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACK   = 2'd1,
    OP_POLL  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CMD_HOMEFLAG = 3'd0,
    CMD_ENABLE   = 3'd1,
    CMD_SPEED    = 3'd2,
    CMD_MOVE     = 3'd3,
    CMD_STATUS   = 3'd4,
    CMD_ZERO     = 3'd5,
    CMD_DISABLE  = 3'd6,
    CMD_FINISHED = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_NONE    = 3'd0,
    OUT_DONE    = 3'd1,
    OUT_FAILED  = 3'd2,
    OUT_DEVERR  = 3'd3,
    OUT_TIMEOUT = 3'd4
  } outcome_t;

  typedef enum logic [16:0] {
    PH_IDLE          = 17'h00001,
    PH_ACK_FLAG0     = 17'h00002,
    PH_ACK_ENABLE    = 17'h00004,
    PH_ACK_SPEED     = 17'h00008,
    PH_ACK_APPROACH  = 17'h00010,
    PH_WAIT_NEG1     = 17'h00020,
    PH_ACK_JOG       = 17'h00040,
    PH_WAIT_JOGSTOP  = 17'h00080,
    PH_ACK_SLOWSPEED = 17'h00100,
    PH_ACK_SLOWMOVE  = 17'h00200,
    PH_WAIT_NEG2     = 17'h00400,
    PH_ACK_ZERO      = 17'h00800,
    PH_ACK_SPEED2    = 17'h01000,
    PH_ACK_HOMEMOVE  = 17'h02000,
    PH_WAIT_HOMESTOP = 17'h04000,
    PH_ACK_FLAG1     = 17'h08000,
    PH_ACK_DISABLE   = 17'h10000
  } phase_t;

  typedef struct packed {
    op_t  op;
    logic cmd_failed;
    logic at_negative_limit;
    logic stage_moving;
    logic device_error;
    logic stage_enabled;
  } item_t;

  typedef struct packed {
    cmd_t                    command;
    logic signed [ARG_W-1:0] argument;
    outcome_t                outcome;
    logic                    busy_res;
  } res_t;

  typedef struct packed {
    logic [SPEED_W-1:0]      run_speed;
    logic [SPEED_W-1:0]      slow_speed;
    logic signed [ARG_W-1:0] approach_distance;
    logic signed [ARG_W-1:0] jog_distance;
    logic signed [ARG_W-1:0] slow_approach_distance;
    logic signed [ARG_W-1:0] home_offset;
    logic [POLL_W-1:0]       poll_limit;
    logic [JOG_W-1:0]        jog_limit;
  } cfg_t;

endpackage

`default_nettype wire

[sv/shs_cfg_regs.sv]
// Configuration registers of the homing sequencer, with the slow speed
// worked out once at write time. Depends on shs_pkg.
`default_nettype none

module shs_cfg_regs
  import shs_pkg::*;
#(
  parameter int unsigned DIST_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ARG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  // Distances are kept at the stored width and sign extended on the way out.
  localparam int unsigned DW = (DIST_WIDTH < ARG_W) ? DIST_WIDTH : ARG_W;

  logic [SPEED_W-1:0]     run_speed_r;
  logic [SPEED_W-1:0]     slow_speed_r;
  logic signed [DW-1:0]   approach_r;
  logic signed [DW-1:0]   jog_dist_r;
  logic signed [DW-1:0]   slow_dist_r;
  logic signed [DW-1:0]   home_off_r;
  logic [POLL_W-1:0]      poll_limit_r;
  logic [JOG_W-1:0]       jog_limit_r;
  logic [2*SPEED_W-1:0]   speed_prod;
  logic [SPEED_W-1:0]     slow_speed_nxt;

  assign speed_prod     = (2*SPEED_W)'(cfg_wdata[SPEED_W-1:0]) * (2*SPEED_W)'(SPEED_DIV_MULT);
  assign slow_speed_nxt = SPEED_W'(speed_prod >> SPEED_DIV_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_speed_r  <= RUN_SPEED_RST;
      slow_speed_r <= SLOW_SPEED_RST;
      approach_r   <= '0;
      jog_dist_r   <= '0;
      slow_dist_r  <= '0;
      home_off_r   <= '0;
      poll_limit_r <= POLL_LIMIT_RST;
      jog_limit_r  <= JOG_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_SPEED: begin
          run_speed_r  <= cfg_wdata[SPEED_W-1:0];
          slow_speed_r <= slow_speed_nxt;
        end
        REG_APPROACH_DIST: approach_r   <= cfg_wdata[DW-1:0];
        REG_JOG_DIST:      jog_dist_r   <= cfg_wdata[DW-1:0];
        REG_SLOW_DIST:     slow_dist_r  <= cfg_wdata[DW-1:0];
        REG_HOME_OFFSET:   home_off_r   <= cfg_wdata[DW-1:0];
        REG_POLL_LIMIT:    poll_limit_r <= cfg_wdata[POLL_W-1:0];
        REG_JOG_LIMIT:     jog_limit_r  <= cfg_wdata[JOG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.run_speed              = run_speed_r;
  assign cfg.slow_speed             = slow_speed_r;
  assign cfg.approach_distance      = ARG_W'(approach_r);
  assign cfg.jog_distance           = ARG_W'(jog_dist_r);
  assign cfg.slow_approach_distance = ARG_W'(slow_dist_r);
  assign cfg.home_offset            = ARG_W'(home_off_r);
  assign cfg.poll_limit             = poll_limit_r;
  assign cfg.jog_limit              = jog_limit_r;

endmodule

`default_nettype wire

[sv/shs_seq_core.sv]
// Phase register, poll and jog counters, and the decision logic that turns
// one item into at most one command. Depends on shs_pkg.
`default_nettype none

module shs_seq_core
  import shs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t item,
  input  wire logic  fire,
  input  wire cfg_t  cfg,
  output logic       res_valid,
  output res_t       res
);

  phase_t              phase_r, phase_nxt;
  logic [POLL_W-1:0]   poll_cnt_r, poll_cnt_nxt;
  logic [JOG_W-1:0]    jog_cnt_r, jog_cnt_nxt;
  logic [JOG_W-1:0]    jog_inc;
  logic                in_wait;
  logic                wait_done;

  // Next command proposed by an acknowledge, before the failure check.
  logic                    ack_hit;
  logic                    ack_strict;
  logic                    ack_clear_poll;
  phase_t                  ack_phase;
  cmd_t                    ack_cmd;
  logic signed [ARG_W-1:0] ack_arg;

  assign jog_inc = jog_cnt_r + JOG_W'(1);
  assign in_wait = (phase_r == PH_WAIT_NEG1) || (phase_r == PH_WAIT_JOGSTOP) ||
                   (phase_r == PH_WAIT_NEG2) || (phase_r == PH_WAIT_HOMESTOP);
  assign wait_done = ((phase_r == PH_WAIT_NEG1) || (phase_r == PH_WAIT_NEG2)) ?
                     item.at_negative_limit : !item.stage_moving;

  always_comb begin
    ack_hit        = 1'b1;
    ack_strict     = 1'b1;
    ack_clear_poll = 1'b0;
    ack_phase      = phase_r;
    ack_cmd        = CMD_FINISHED;
    ack_arg        = '0;
    unique case (phase_r)
      PH_ACK_FLAG0: begin
        ack_strict = 1'b0;
        ack_phase  = PH_ACK_ENABLE;
        ack_cmd    = CMD_ENABLE;
      end
      PH_ACK_ENABLE: begin
        ack_strict = 1'b0;
        ack_phase  = PH_ACK_SPEED;
        ack_cmd    = CMD_SPEED;
        ack_arg    = ARG_W'(cfg.run_speed);
      end
      PH_ACK_SPEED: begin
        if (!item.at_negative_limit) begin
          ack_phase = PH_ACK_APPROACH;
          ack_cmd   = CMD_MOVE;
          ack_arg   = cfg.approach_distance;
        end else begin
          ack_clear_poll = 1'b1;
          ack_phase      = PH_WAIT_NEG1;
          ack_cmd        = CMD_STATUS;
        end
      end
      PH_ACK_APPROACH: begin
        ack_clear_poll = 1'b1;
        ack_phase      = PH_WAIT_NEG1;
        ack_cmd        = CMD_STATUS;
      end
      PH_ACK_JOG: begin
        ack_clear_poll = 1'b1;
        ack_phase      = PH_WAIT_JOGSTOP;
        ack_cmd        = CMD_STATUS;
      end
      PH_ACK_SLOWSPEED: begin
        ack_phase = PH_ACK_SLOWMOVE;
        ack_cmd   = CMD_MOVE;
        ack_arg   = cfg.slow_approach_distance;
      end
      PH_ACK_SLOWMOVE: begin
        ack_clear_poll = 1'b1;
        ack_phase      = PH_WAIT_NEG2;
        ack_cmd        = CMD_STATUS;
      end
      PH_ACK_ZERO: begin
        ack_phase = PH_ACK_SPEED2;
        ack_cmd   = CMD_SPEED;
        ack_arg   = ARG_W'(cfg.run_speed);
      end
      PH_ACK_SPEED2: begin
        ack_phase = PH_ACK_HOMEMOVE;
        ack_cmd   = CMD_MOVE;
        ack_arg   = cfg.home_offset;
      end
      PH_ACK_HOMEMOVE: begin
        ack_clear_poll = 1'b1;
        ack_phase      = PH_WAIT_HOMESTOP;
        ack_cmd        = CMD_STATUS;
      end
      PH_ACK_FLAG1: begin
        ack_strict = 1'b0;
        ack_phase  = PH_ACK_DISABLE;
        ack_cmd    = CMD_DISABLE;
      end
      PH_ACK_DISABLE: begin
        // A failure on the final disable is ignored; the run completes.
        ack_strict = 1'b0;
        ack_phase  = PH_IDLE;
      end
      default: begin
        ack_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    poll_cnt_nxt = poll_cnt_r;
    jog_cnt_nxt  = jog_cnt_r;
    res_valid    = 1'b0;
    res.command  = CMD_FINISHED;
    res.argument = '0;
    res.outcome  = OUT_NONE;
    case (item.op)
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          poll_cnt_nxt = '0;
          jog_cnt_nxt  = '0;
          phase_nxt    = PH_ACK_FLAG0;
          res_valid    = 1'b1;
          res.command  = CMD_HOMEFLAG;
        end
      end
      OP_ACK: begin
        if (ack_hit) begin
          res_valid = 1'b1;
          if (ack_strict && item.cmd_failed) begin
            phase_nxt   = PH_IDLE;
            res.outcome = OUT_FAILED;
          end else begin
            phase_nxt    = ack_phase;
            res.command  = ack_cmd;
            res.argument = ack_arg;
            if (ack_phase == PH_IDLE) begin
              res.outcome = OUT_DONE;
            end
            if (ack_clear_poll) begin
              poll_cnt_nxt = '0;
            end
          end
        end
      end
      OP_POLL: begin
        if (in_wait) begin
          // Error check, timeout check and exit test all use this one sample.
          if (item.device_error || !item.stage_enabled) begin
            phase_nxt   = PH_IDLE;
            res_valid   = 1'b1;
            res.outcome = OUT_DEVERR;
          end else if (poll_cnt_r >= cfg.poll_limit) begin
            phase_nxt   = PH_IDLE;
            res_valid   = 1'b1;
            res.outcome = OUT_TIMEOUT;
          end else begin
            poll_cnt_nxt = poll_cnt_r + POLL_W'(1);
            if (wait_done) begin
              res_valid = 1'b1;
              unique case (phase_r)
                PH_WAIT_NEG1: begin
                  jog_cnt_nxt  = '0;
                  phase_nxt    = PH_ACK_JOG;
                  res.command  = CMD_MOVE;
                  res.argument = cfg.jog_distance;
                end
                PH_WAIT_JOGSTOP: begin
                  jog_cnt_nxt = jog_inc;
                  if (item.at_negative_limit && (jog_inc < cfg.jog_limit)) begin
                    phase_nxt    = PH_ACK_JOG;
                    res.command  = CMD_MOVE;
                    res.argument = cfg.jog_distance;
                  end else begin
                    phase_nxt    = PH_ACK_SLOWSPEED;
                    res.command  = CMD_SPEED;
                    res.argument = ARG_W'(cfg.slow_speed);
                  end
                end
                PH_WAIT_NEG2: begin
                  phase_nxt   = PH_ACK_ZERO;
                  res.command = CMD_ZERO;
                end
                default: begin
                  phase_nxt    = PH_ACK_FLAG1;
                  res.command  = CMD_HOMEFLAG;
                  res.argument = ARG_W'(1);
                end
              endcase
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      poll_cnt_r <= '0;
      jog_cnt_r  <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      jog_cnt_r  <= jog_cnt_nxt;
    end
  end

  a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && (res.command == CMD_FINISHED) |=> phase_r == PH_IDLE)
    else $error("finished command did not return the sequencer to idle");

  a_wait_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.op == OP_POLL) && in_wait && !res_valid
    |=> poll_cnt_r == $past(poll_cnt_r) + POLL_W'(1))
    else $error("poll tick in a wait did not advance the poll counter");

  a_silent_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res_valid && !in_wait |=> $stable(phase_r))
    else $error("ignored item changed the phase");

endmodule

`default_nettype wire

[sv/stage_homing_sequencer.sv]
// Top level of the stage homing sequencer: input register, sequencer core,
// result register. Depends on shs_pkg, shs_cfg_regs and shs_seq_core.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | in        | in_valid/in_ready  | op, cmd_failed, stage flags
//  out_    | out       | out_valid/out_ready| command, argument, outcome, busy_res
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata (no read-back)
//
// One item per cycle is sustained while the result register can take results; an item is
// first held in the input register, and its result is then captured in the result register.
// Items that cause no result retire from the input register without waiting.
// A stalled result only holds the input register when that item also has a result.
// Synchronous active-low reset returns the sequencer to idle with counters cleared.
`default_nettype none

module stage_homing_sequencer
  import shs_pkg::*;
#(
  parameter int unsigned DIST_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_op,
  input  wire logic                    in_cmd_failed,
  input  wire logic                    in_at_negative_limit,
  input  wire logic                    in_stage_moving,
  input  wire logic                    in_device_error,
  input  wire logic                    in_stage_enabled,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_command,
  output logic signed [ARG_W-1:0]      out_argument,
  output logic [2:0]                   out_outcome,
  output logic                         out_busy_res,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ARG_W-1:0]        cfg_wdata
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  logic  s1_adv;
  logic  core_res_valid;
  res_t  core_res;
  logic  out_valid_r;
  res_t  out_res_r;
  logic  out_free;

  shs_cfg_regs #(
    .DIST_WIDTH(DIST_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  shs_seq_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (s1_item_r),
    .fire     (s1_adv),
    .cfg      (cfg),
    .res_valid(core_res_valid),
    .res      (core_res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!core_res_valid || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.op                <= op_t'(in_op);
      s1_item_r.cmd_failed        <= in_cmd_failed;
      s1_item_r.at_negative_limit <= in_at_negative_limit;
      s1_item_r.stage_moving      <= in_stage_moving;
      s1_item_r.device_error      <= in_device_error;
      s1_item_r.stage_enabled     <= in_stage_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_command  = out_res_r.command;
  assign out_argument = out_res_r.argument;
  assign out_outcome  = out_res_r.outcome;
  assign out_busy_res = out_res_r.busy_res;

  a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("held input item was lost or changed");

  a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && core_res_valid |=> out_valid_r && (out_res_r == $past(core_res)))
    else $error("result was not captured in the output register");

  a_finished_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.command == CMD_FINISHED) |-> !out_res_r.busy_res)
    else $error("finished result still reports a run in progress");

  a_command_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.command != CMD_FINISHED) |-> out_res_r.outcome == OUT_NONE)
    else $error("outcome set on a command other than finished");

endmodule

`default_nettype wire
